/* hw/rtl/csob_pkg.sv */
// Shared types, constants and helper functions of the cursor overlay blend.
// No dependencies.
package csob_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam int NUM_W = 16;  // rel * 100 for rel < 512
  localparam int DVS_W = 9;
  localparam int REM_W = 10;

  localparam logic [8:0] SCALE_UNITY  = 9'd100;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    REG_BOX_LEFT,
    REG_BOX_TOP,
    REG_BOX_WIDTH,
    REG_BOX_HEIGHT,
    REG_SPRITE_START,
    REG_SCALE_PERCENT,
    REG_SPRITE_WIDTH,
    REG_SPRITE_HEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic        cmd;
    logic [11:0] sprite_index;
    logic [31:0] sprite_word;
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
    logic [31:0] background;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        cursor_hit;
  } out_item_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] sprite_index;
    logic [31:0] sprite_word;
    logic [31:0] background;
    logic        hit;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } dstep_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

  // one restoring division step
  function automatic dstep_t div_step(dstep_t s, logic [DVS_W-1:0] d);
    dstep_t           r;
    logic [REM_W-1:0] sh;
    sh    = {s.rem[REM_W-2:0], s.quo[NUM_W-1]};
    r.quo = {s.quo[NUM_W-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      r.rem    = sh - {1'b0, d};
      r.quo[0] = 1'b1;
    end else begin
      r.rem = sh;
    end
    return r;
  endfunction

  // floor(x / 255) for x <= 255 * 255
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

/* hw/rtl/cursor_sprite_overlay_blend.sv */
// Cursor overlay plane: box test, scaled texel lookup, alpha blend.
// Depends on csob_pkg, csob_div, csob_store.
//
//   channel   dir  handshake          payload
//   in        in   in_valid/in_stall  in_item_t (load or pixel)
//   out       out  out_valid/out_stall out_item_t (one per pixel)
//   cfg       in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle while out_stall_i is low; pixels pass the box test stage, the 16 stage
// divider, then clamp, address multiply, store read, blend and output stages.
// Loads travel the same pipe and write the store in order with pixel reads.
// Reset clears all valid state and sets the config defaults; store is not cleared.
// Stalls ripple back only through full stages; bubbles are absorbed.
module cursor_sprite_overlay_blend #(
  parameter int SPRITE_WORDS    = 4096,
  parameter int MAX_SPRITE_SIDE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csob_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csob_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);
  import csob_pkg::*;

  localparam int AW     = $clog2(SPRITE_WORDS);
  localparam int SIDE_W = $clog2(MAX_SPRITE_SIDE + 1);
  localparam int AFW0   = (2 * SIDE_W > AW) ? 2 * SIDE_W : AW;
  localparam int AFW    = ((AFW0 > 12) ? AFW0 : 12) + 1;

  // config
  logic [11:0] box_left_q, box_top_q, sprite_start_q;
  logic [8:0]  box_width_q, box_height_q, scale_q;
  logic [6:0]  sprite_width_q, sprite_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q      <= '0;
      box_top_q       <= '0;
      box_width_q     <= 9'd32;
      box_height_q    <= 9'd32;
      sprite_start_q  <= '0;
      scale_q         <= SCALE_UNITY;
      sprite_width_q  <= 7'd32;
      sprite_height_q <= 7'd32;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BOX_LEFT:      box_left_q      <= cfg_data_i;
        REG_BOX_TOP:       box_top_q       <= cfg_data_i;
        REG_BOX_WIDTH:     box_width_q     <= cfg_data_i[8:0];
        REG_BOX_HEIGHT:    box_height_q    <= cfg_data_i[8:0];
        REG_SPRITE_START:  sprite_start_q  <= cfg_data_i;
        REG_SCALE_PERCENT: scale_q         <= cfg_data_i[8:0];
        REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data_i[6:0];
        REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [8:0]        scale_eff;
  logic [SIDE_W-1:0] w_eff, h_eff;

  function automatic logic [SIDE_W-1:0] side_limit(logic [6:0] v);
    logic [7:0] v8;
    logic [7:0] mx;
    v8 = {1'b0, v};
    mx = 8'(MAX_SPRITE_SIDE);
    if (v8 == 8'd0) return SIDE_W'(1);
    if (v8 > mx) return SIDE_W'(mx);
    return SIDE_W'(v8);
  endfunction

  assign scale_eff = (scale_q == 9'd0) ? SCALE_UNITY : scale_q;
  assign w_eff     = side_limit(sprite_width_q);
  assign h_eff     = side_limit(sprite_height_q);

  // ready chain
  logic s0_ready, div_ready, c_ready, a_ready, m_ready, mx_ready, o_ready;

  // stage 0: box test, rel * 100
  logic              s0_v_q;
  side_t             s0_side_q;
  logic [NUM_W-1:0]  s0_nx_q, s0_ny_q;
  logic [11:0]       rel_x, rel_y;
  logic              in_box;

  assign rel_x  = in_item_i.pixel_col - box_left_q;
  assign rel_y  = in_item_i.pixel_row - box_top_q;
  assign in_box = (in_item_i.pixel_col >= box_left_q) && (rel_x < {3'd0, box_width_q}) &&
                  (in_item_i.pixel_row >= box_top_q) && (rel_y < {3'd0, box_height_q});

  assign s0_ready   = !s0_v_q || div_ready;
  assign in_stall_o = !s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (s0_ready) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready) begin
      s0_side_q.cmd          <= in_item_i.cmd;
      s0_side_q.sprite_index <= in_item_i.sprite_index;
      s0_side_q.sprite_word  <= in_item_i.sprite_word;
      s0_side_q.background   <= in_item_i.background;
      s0_side_q.hit          <= in_box;
      s0_nx_q <= {7'd0, rel_x[8:0]} * NUM_W'(100);
      s0_ny_q <= {7'd0, rel_y[8:0]} * NUM_W'(100);
    end
  end

  // divider
  logic             d_v;
  side_t            d_side;
  logic [NUM_W-1:0] d_qx, d_qy;

  csob_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_v_q),
    .in_ready_o  (div_ready),
    .side_i      (s0_side_q),
    .num_x_i     (s0_nx_q),
    .num_y_i     (s0_ny_q),
    .divisor_i   (scale_eff),
    .out_valid_o (d_v),
    .out_ready_i (c_ready),
    .side_o      (d_side),
    .quo_x_o     (d_qx),
    .quo_y_o     (d_qy)
  );

  // clamp stage
  logic              c_v_q;
  side_t             c_side_q;
  logic [SIDE_W-1:0] c_sx_q, c_sy_q;
  logic [15:0]       sx_full, sy_full;
  logic [SIDE_W-1:0] sx_d, sy_d;

  assign sx_full = {10'd0, sprite_start_q[5:0]} + d_qx;
  assign sy_full = {10'd0, sprite_start_q[11:6]} + d_qy;
  assign sx_d    = (sx_full >= 16'(w_eff)) ? w_eff - SIDE_W'(1) : SIDE_W'(sx_full);
  assign sy_d    = (sy_full >= 16'(h_eff)) ? h_eff - SIDE_W'(1) : SIDE_W'(sy_full);
  assign c_ready = !c_v_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_ready) begin
      c_v_q <= d_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready) begin
      c_side_q <= d_side;
      c_sx_q   <= sx_d;
      c_sy_q   <= sy_d;
    end
  end

  // address stage
  logic           a_v_q, a_ok_q;
  side_t          a_side_q;
  logic [AW-1:0]  a_addr_q;
  logic [AFW-1:0] texel_addr, load_addr, acc_addr;
  logic           acc_ok;

  assign texel_addr = AFW'(c_sy_q) * AFW'(w_eff) + AFW'(c_sx_q);
  assign load_addr  = AFW'(c_side_q.sprite_index);
  assign acc_addr   = (c_side_q.cmd == CMD_PIXEL) ? texel_addr : load_addr;
  assign acc_ok     = acc_addr < AFW'(SPRITE_WORDS);
  assign a_ready    = !a_v_q || m_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_ready) begin
      a_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) begin
      a_side_q <= c_side_q;
      a_addr_q <= acc_addr[AW-1:0];
      a_ok_q   <= acc_ok;
    end
  end

  // store access stage
  logic        m_v_q, m_ok_q;
  side_t       m_side_q;
  store_ctl_t  st_ctl;
  logic [31:0] st_rdata;

  assign m_ready   = !m_v_q || mx_ready;
  assign st_ctl.wr = a_v_q && m_ready && a_ok_q && (a_side_q.cmd == CMD_LOAD);
  assign st_ctl.rd = a_v_q && m_ready && a_ok_q && (a_side_q.cmd == CMD_PIXEL);

  csob_store #(
    .WORDS (SPRITE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (st_ctl),
    .addr_i  (a_addr_q),
    .wdata_i (a_side_q.sprite_word),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (m_ready) begin
      m_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_ready) begin
      m_side_q <= a_side_q;
      m_ok_q   <= a_ok_q;
    end
  end

  // mix stage: products, loads drop out here
  logic        mx_v_q;
  side_t       mx_side_q;
  logic [31:0] mx_texel_q;
  logic [15:0] mx_sum_q [3];
  logic [31:0] texel;
  logic [7:0]  alpha;
  logic [15:0] sum_d [3];

  assign texel    = m_ok_q ? st_rdata : 32'd0;
  assign alpha    = texel[31:24];
  assign mx_ready = !mx_v_q || o_ready;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = 16'(texel[8*c +: 8]) * 16'(alpha) +
                 16'(m_side_q.background[8*c +: 8]) * 16'(ALPHA_OPAQUE - alpha);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx_v_q <= 1'b0;
    end else if (mx_ready) begin
      mx_v_q <= m_v_q && (m_side_q.cmd == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mx_ready) begin
      mx_side_q  <= m_side_q;
      mx_texel_q <= texel;
      for (int c = 0; c < 3; c++) mx_sum_q[c] <= sum_d[c];
    end
  end

  // output stage
  logic       o_v_q;
  out_item_t  o_item_q, o_item_d;
  logic [7:0] mx_alpha;

  assign mx_alpha = mx_texel_q[31:24];
  assign o_ready  = !o_v_q || !out_stall_i;

  always_comb begin
    o_item_d.cursor_hit = mx_side_q.hit;
    if (!mx_side_q.hit || mx_alpha == ALPHA_CLEAR) begin
      o_item_d.out_pixel = mx_side_q.background;
    end else if (mx_alpha == ALPHA_OPAQUE) begin
      o_item_d.out_pixel = mx_texel_q;
    end else begin
      o_item_d.out_pixel = {ALPHA_OPAQUE, div255(mx_sum_q[2]), div255(mx_sum_q[1]),
                            div255(mx_sum_q[0])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= mx_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready) o_item_q <= o_item_d;
  end

  assign out_valid_o = o_v_q;
  assign out_item_o  = o_item_q;

  a_store_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_ctl.wr && st_ctl.rd)) else $error("store read and write in one cycle");

  a_mix_pixels_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mx_v_q |-> (mx_side_q.cmd == CMD_PIXEL)) else $error("load reached blend stage");

  a_mem_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_v_q && !mx_ready) |=> (m_v_q && $stable(m_side_q)))
    else $error("held store stage lost its item");

  a_read_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_ctl.rd |-> (a_v_q && m_ready)) else $error("store read while stage held");

endmodule

/* hw/rtl/csob_div.sv */
// Pipelined restoring divider, two lanes sharing one divisor, one bit per stage.
// Depends on csob_pkg.
module csob_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  csob_pkg::side_t            side_i,
  input  logic [csob_pkg::NUM_W-1:0] num_x_i,
  input  logic [csob_pkg::NUM_W-1:0] num_y_i,
  input  logic [csob_pkg::DVS_W-1:0] divisor_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output csob_pkg::side_t            side_o,
  output logic [csob_pkg::NUM_W-1:0] quo_x_o,
  output logic [csob_pkg::NUM_W-1:0] quo_y_o
);
  import csob_pkg::*;

  logic [NUM_W-1:0] v_q;
  logic [NUM_W-1:0] vin;
  logic [NUM_W:0]   rdy;
  side_t            side_q [NUM_W];
  side_t            side_d [NUM_W];
  dstep_t           x_q    [NUM_W];
  dstep_t           y_q    [NUM_W];
  dstep_t           x_d    [NUM_W];
  dstep_t           y_d    [NUM_W];

  always_comb begin
    rdy[NUM_W] = out_ready_i;
    for (int k = NUM_W - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    vin[0]    = in_valid_i;
    side_d[0] = side_i;
    x_d[0]    = div_step('{rem: '0, quo: num_x_i}, divisor_i);
    y_d[0]    = div_step('{rem: '0, quo: num_y_i}, divisor_i);
    for (int k = 1; k < NUM_W; k++) begin
      vin[k]    = v_q[k-1];
      side_d[k] = side_q[k-1];
      x_d[k]    = div_step(x_q[k-1], divisor_i);
      y_d[k]    = div_step(y_q[k-1], divisor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_W; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_d[k];
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NUM_W-1];
  assign side_o      = side_q[NUM_W-1];
  assign quo_x_o     = x_q[NUM_W-1].quo;
  assign quo_y_o     = y_q[NUM_W-1].quo;

endmodule

/* hw/rtl/csob_store.sv */
// Sprite store: single port synchronous RAM, registered read data.
// Depends on csob_pkg.
module csob_store #(
  parameter int WORDS = 4096,
  parameter int AW    = 12
) (
  input  logic                 clk_i,
  input  csob_pkg::store_ctl_t ctl_i,
  input  logic [AW-1:0]        addr_i,
  input  logic [31:0]          wdata_i,
  output logic [31:0]          rdata_o
);
  import csob_pkg::*;

  logic [31:0] mem_q [WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) mem_q[addr_i] <= wdata_i;
    if (ctl_i.rd) rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/tb_cursor_sprite_overlay_blend.sv */
// Self-checking testbench of cursor_sprite_overlay_blend: drives loads and pixels,
// predicts overlay results in a scoreboard class and checks them in order.
// Depends on csob_pkg and the cursor_sprite_overlay_blend RTL.
`timescale 1ns / 1ps

module tb_cursor_sprite_overlay_blend;
  import csob_pkg::*;

  localparam int STORE_DEPTH = 4096;
  localparam int SIDE_MAX    = 64;
  localparam int DRAIN_CYC   = 40;
  localparam int CYCLE_LIMIT = 400000;

  class overlay_scoreboard;
    bit [11:0]   left, top, start;
    bit [8:0]    bw, bh, scale;
    bit [6:0]    sw, sh;
    logic [31:0] texels[STORE_DEPTH];
    bit          written[STORE_DEPTH];
    out_item_t   pending[$];
    int          errors;

    function new();
      left = 0; top = 0; bw = 32; bh = 32;
      start = 0; scale = 100; sw = 32; sh = 32;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [11:0] d);
      case (idx)
        REG_BOX_LEFT:      left  = d;
        REG_BOX_TOP:       top   = d;
        REG_BOX_WIDTH:     bw    = d[8:0];
        REG_BOX_HEIGHT:    bh    = d[8:0];
        REG_SPRITE_START:  start = d;
        REG_SCALE_PERCENT: scale = d[8:0];
        REG_SPRITE_WIDTH:  sw    = d[6:0];
        REG_SPRITE_HEIGHT: sh    = d[6:0];
        default: ;
      endcase
    endfunction

    function bit hits(logic [11:0] col, logic [11:0] row);
      int unsigned c, r;
      c = col; r = row;
      return c >= left && (c - left) < bw && r >= top && (r - top) < bh;
    endfunction

    function int unsigned clamp_side(int unsigned v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return v;
    endfunction

    function int unsigned texel_addr(logic [11:0] col, logic [11:0] row);
      int unsigned sc, w, h, sx, sy;
      sc = (scale == 0) ? 100 : scale;
      w  = clamp_side(sw);
      h  = clamp_side(sh);
      sx = start[5:0] + ((col - left) * 100) / sc;
      sy = start[11:6] + ((row - top) * 100) / sc;
      if (sx >= w) sx = w - 1;
      if (sy >= h) sy = h - 1;
      return sy * w + sx;
    endfunction

    function out_item_t overlay(in_item_t it);
      out_item_t   o;
      int unsigned addr, a, s, b;
      logic [31:0] t;
      o.out_pixel  = it.background;
      o.cursor_hit = hits(it.pixel_col, it.pixel_row);
      if (!o.cursor_hit) return o;
      addr = texel_addr(it.pixel_col, it.pixel_row);
      t = (addr < STORE_DEPTH) ? texels[addr] : 32'h0;
      a = t[31:24];
      if (a == 255) o.out_pixel = t;
      else if (a != 0) begin
        o.out_pixel[31:24] = 8'hFF;
        for (int ch = 0; ch < 3; ch++) begin
          s = t[8*ch +: 8];
          b = it.background[8*ch +: 8];
          o.out_pixel[8*ch +: 8] = 8'((s * a + b * (255 - a)) / 255);
        end
      end
      return o;
    endfunction

    function void note_input(in_item_t it);
      if (it.cmd == CMD_LOAD) begin
        texels[it.sprite_index]  = it.sprite_word;
        written[it.sprite_index] = 1;
      end else begin
        pending.push_back(overlay(it));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending.size() == 0) begin
        $error("unexpected result out_pixel=%h cursor_hit=%b", got.out_pixel, got.cursor_hit);
        errors++;
        return;
      end
      exp_item = pending.pop_front();
      if (got.out_pixel !== exp_item.out_pixel) begin
        $error("out_pixel expected %h actual %h", exp_item.out_pixel, got.out_pixel);
        errors++;
      end
      if (got.cursor_hit !== exp_item.cursor_hit) begin
        $error("cursor_hit expected %b actual %b", exp_item.cursor_hit, got.cursor_hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o, out_stall_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  overlay_scoreboard sb = new();
  bit calm, hold_req;
  int hold_left, cycles;

  cursor_sprite_overlay_blend uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cursor_sprite_overlay_blend verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 16);
    end
  end

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    if (!calm && $urandom_range(99) < 16) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic load_word(logic [11:0] idx, logic [31:0] word);
    in_item_t it;
    it = '{cmd: CMD_LOAD, sprite_index: idx, sprite_word: word,
           pixel_col: 12'($urandom), pixel_row: 12'($urandom), background: $urandom};
    send_item(it);
  endtask

  // loads the texel a pixel would read first if it was never written
  task automatic show_pixel(logic [11:0] col, logic [11:0] row, logic [31:0] bg);
    in_item_t    it;
    int unsigned addr;
    if (sb.hits(col, row)) begin
      addr = sb.texel_addr(col, row);
      if (addr < STORE_DEPTH && !sb.written[addr]) load_word(addr[11:0], $urandom);
    end
    it = '{cmd: CMD_PIXEL, sprite_index: 12'($urandom), sprite_word: $urandom,
           pixel_col: col, pixel_row: row, background: bg};
    send_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [11:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(logic [11:0] l, logic [11:0] t, logic [11:0] w, logic [11:0] h,
                         logic [11:0] st, logic [11:0] sc, logic [11:0] sw, logic [11:0] sh);
    drain();
    write_cfg(REG_BOX_LEFT, l);
    write_cfg(REG_BOX_TOP, t);
    write_cfg(REG_BOX_WIDTH, w);
    write_cfg(REG_BOX_HEIGHT, h);
    write_cfg(REG_SPRITE_START, st);
    write_cfg(REG_SCALE_PERCENT, sc);
    write_cfg(REG_SPRITE_WIDTH, sw);
    write_cfg(REG_SPRITE_HEIGHT, sh);
  endtask

  function automatic logic [31:0] rand_texel();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(3))
      0: w[31:24] = ALPHA_CLEAR;
      1: w[31:24] = ALPHA_OPAQUE;
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_items(int n);
    int c, r;
    repeat (n) begin
      if ($urandom_range(99) < 30) begin
        load_word(12'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1023)),
                  rand_texel());
      end else if ($urandom_range(99) < 15) begin
        show_pixel(12'($urandom), 12'($urandom), $urandom);
      end else begin
        c = int'(sb.left) + $urandom_range(0, sb.bw + 3) - 2;
        r = int'(sb.top) + $urandom_range(0, sb.bh + 3) - 2;
        show_pixel(c[11:0], r[11:0], $urandom);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    calm = 0; hold_req = 0; hold_left = 0; cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: clear, opaque and mid alpha, box edges, outside
    load_word(12'd0, 32'h00123456);
    show_pixel(12'd0, 12'd0, 32'hA5A5A5A5);
    load_word(12'd0, 32'hFFABCDEF);
    show_pixel(12'd0, 12'd0, 32'h00000000);
    load_word(12'd0, 32'h80FF00FF);
    show_pixel(12'd0, 12'd0, 32'hFFFFFFFF);
    load_word(12'd0, 32'h01FFFFFF);
    show_pixel(12'd0, 12'd0, 32'h00000000);
    load_word(12'd4095, 32'hFFFFFFFF);
    show_pixel(12'd31, 12'd31, 32'h12345678);
    show_pixel(12'd32, 12'd0, 32'hFFFFFFFF);
    show_pixel(12'd0, 12'd32, 32'h0F0F0F0F);
    show_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
    show_pixel(12'd31, 12'd0, 32'h00000000);

    // zero scale, zero sides, hidden cursor
    set_all(12'd0, 12'd0, 12'd0, 12'd8, 12'd0, 12'd0, 12'd0, 12'd0);
    show_pixel(12'd0, 12'd0, 32'hDEADBEEF);
    drain();
    write_cfg(REG_BOX_WIDTH, 12'd8);
    write_cfg(REG_BOX_HEIGHT, 12'd0);
    show_pixel(12'd0, 12'd0, 32'hCAFEF00D);
    drain();
    write_cfg(REG_BOX_HEIGHT, 12'd8);
    random_items(30);

    // large box, maximum reduction, full sprite
    set_all(12'd0, 12'd0, 12'd256, 12'd256, 12'd0, 12'd1, 12'd64, 12'd64);
    random_items(40);

    // far corner, widest field values, oversize sides saturate
    set_all(12'd4095, 12'd4095, 12'd511, 12'd511, 12'd4095, 12'd511, 12'd127, 12'd127);
    show_pixel(12'd4095, 12'd4095, 32'h55AA55AA);
    random_items(20);

    // receiver holds off while sender keeps offering
    set_all(12'd100, 12'd50, 12'd40, 12'd30, 12'd130, 12'd250, 12'd20, 12'd12);
    hold_req = 1;
    random_items(80);
    drain();

    // quiet stretch with no idling on either side
    calm = 1;
    random_items(60);
    calm = 0;

    for (int p = 0; p < 4; p++) begin
      set_all(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              12'($urandom_range(1, 256)), 12'($urandom_range(1, 256)),
              12'($urandom_range(0, 4095)), 12'($urandom_range(1, 400)),
              12'($urandom_range(1, 64)), 12'($urandom_range(1, 64)));
      random_items(40);
    end

    drain();
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) $display("cursor_sprite_overlay_blend verification clean");
    else $display("cursor_sprite_overlay_blend verification failed");
    $finish;
  end

endmodule

/* cursor_sprite_overlay_blend.f */
hw/rtl/csob_pkg.sv
hw/rtl/csob_div.sv
hw/rtl/csob_store.sv
hw/rtl/cursor_sprite_overlay_blend.sv
tb/sv/tb_cursor_sprite_overlay_blend.sv
